### rtl/core/simx_pkg.sv
// shared types and constants for the scanline irq, multiplier and extended ram block
// no dependencies
`default_nettype none

package simx_pkg;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [15:0] EXRAM_BASE  = 16'h5C00;
   localparam logic [15:0] ADDR_EXMODE = 16'h5104;
   localparam logic [15:0] ADDR_TARGET = 16'h5203;
   localparam logic [15:0] ADDR_IRQ    = 16'h5204;
   localparam logic [15:0] ADDR_MUL_A  = 16'h5205;
   localparam logic [15:0] ADDR_MUL_B  = 16'h5206;

   localparam logic [1:0] EXMODE_NT   = 2'd0;
   localparam logic [1:0] EXMODE_ATTR = 2'd1;
   localparam logic [1:0] EXMODE_RW   = 2'd2;
   localparam logic [1:0] EXMODE_RO   = 2'd3;

   localparam logic [7:0] IRQ_ENABLE_VALUE = 8'h80;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        rendering;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_out;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [7:0] data;
   } exram_wr_type;

endpackage

`default_nettype wire

### rtl/core/simx_exram.sv
// extended ram store with registered read, write-to-read bypass and clearing sweep
// depends on simx_pkg
`default_nettype none

module simx_exram #(
   parameter int EXRAM_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(EXRAM_DEPTH)-1:0]   rd_idx,
   input  simx_pkg::exram_wr_type                wr,
   input  wire logic [$clog2(EXRAM_DEPTH)-1:0]   wr_idx,
   output logic [7:0]                            rd_data,
   output logic                                  clearing
);
   import simx_pkg::*;

   localparam int IDX_W = $clog2(EXRAM_DEPTH);

   logic [7:0]       mem [EXRAM_DEPTH];
   logic [7:0]       mem_rd_ff;
   logic [7:0]       byp_data_ff;
   logic             byp_sel_ff;
   logic             clear_busy_ff, clear_busy_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;
   logic             we;
   logic [IDX_W-1:0] we_idx;
   logic [7:0]       we_data;

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_idx_in  = clear_idx_ff;
      if (clear_busy_ff) begin
         clear_idx_in = clear_idx_ff + IDX_W'(1);
         if (clear_idx_ff == IDX_W'(EXRAM_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
      end
   end

   // sweep owns the write port until done
   always_comb begin
      we      = clear_busy_ff | wr.en;
      we_idx  = clear_busy_ff ? clear_idx_ff : wr_idx;
      we_data = clear_busy_ff ? 8'd0 : wr.data;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[we_idx] <= we_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx];
         byp_sel_ff  <= wr.en && (wr_idx == rd_idx);
         byp_data_ff <= wr.data;
      end
   end

   assign rd_data  = byp_sel_ff ? byp_data_ff : mem_rd_ff;
   assign clearing = clear_busy_ff;

endmodule

`default_nettype wire

### rtl/core/simx_core.sv
// register file, bus decode, scanline counter and multiplier for one item
// depends on simx_pkg
`default_nettype none

module simx_core #(
   parameter int EXRAM_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             fire,
   input  simx_pkg::req_type                     item,
   input  wire logic [7:0]                       mem_rd_data,
   output simx_pkg::rsp_type                     result,
   output simx_pkg::exram_wr_type                mem_wr,
   output logic [$clog2(EXRAM_DEPTH)-1:0]        mem_wr_idx
);
   import simx_pkg::*;

   localparam int IDX_W = $clog2(EXRAM_DEPTH);

   logic [1:0]  exram_mode_ff, exram_mode_in;
   logic [7:0]  scanline_target_ff, scanline_target_in;
   logic [7:0]  irq_enable_byte_ff, irq_enable_byte_in;
   logic [7:0]  scanline_count_ff, scanline_count_in;
   logic        in_frame_ff, in_frame_in;
   logic        irq_pending_ff, irq_pending_in;
   logic        irq_level_ff, irq_level_in;
   logic [7:0]  mul_a_ff, mul_a_in;
   logic [7:0]  mul_b_ff, mul_b_in;
   logic [15:0] product_ff, product_in;
   logic [7:0]  rd;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic        is_ex;
   logic [7:0]  count_inc;

   always_comb begin
      exram_mode_in      = exram_mode_ff;
      scanline_target_in = scanline_target_ff;
      irq_enable_byte_in = irq_enable_byte_ff;
      scanline_count_in  = scanline_count_ff;
      in_frame_in        = in_frame_ff;
      irq_pending_in     = irq_pending_ff;
      irq_level_in       = irq_level_ff;
      mul_a_in           = mul_a_ff;
      mul_b_in           = mul_b_ff;
      product_in         = product_ff;
      rd                 = 8'd0;
      wr_en              = 1'b0;
      wr_data            = item.write_data;
      is_ex              = item.address >= EXRAM_BASE;
      count_inc          = scanline_count_ff + 8'd1;

      case (item.kind)
         KIND_WRITE: begin
            if (is_ex) begin
               case (exram_mode_ff)
                  EXMODE_NT, EXMODE_ATTR: begin
                     wr_en   = 1'b1;
                     wr_data = in_frame_ff ? item.write_data : 8'd0;
                  end
                  EXMODE_RW: begin
                     wr_en = 1'b1;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end else begin
               case (item.address)
                  ADDR_EXMODE: exram_mode_in      = item.write_data[1:0];
                  ADDR_TARGET: scanline_target_in = item.write_data;
                  ADDR_IRQ:    irq_enable_byte_in = item.write_data;
                  ADDR_MUL_A: begin
                     mul_a_in   = item.write_data;
                     product_in = {8'd0, item.write_data} * {8'd0, mul_b_ff};
                  end
                  ADDR_MUL_B: begin
                     mul_b_in   = item.write_data;
                     product_in = {8'd0, mul_a_ff} * {8'd0, item.write_data};
                  end
                  default: begin
                     product_in = product_ff;
                  end
               endcase
            end
         end
         KIND_READ: begin
            if (is_ex) begin
               // only the two cpu-access modes return the stored byte
               rd = exram_mode_ff[1] ? mem_rd_data : 8'd0;
            end else begin
               case (item.address)
                  ADDR_IRQ: begin
                     rd             = {irq_pending_ff, in_frame_ff, 6'd0};
                     irq_pending_in = 1'b0;
                     irq_level_in   = 1'b0;
                  end
                  ADDR_MUL_A: rd = product_ff[7:0];
                  ADDR_MUL_B: rd = product_ff[15:8];
                  default:    rd = 8'd0;
               endcase
            end
         end
         KIND_TICK: begin
            if (item.rendering) begin
               in_frame_in       = 1'b1;
               scanline_count_in = count_inc;
               if (count_inc == scanline_target_ff) begin
                  irq_pending_in = 1'b1;
                  if (irq_enable_byte_ff == IRQ_ENABLE_VALUE) begin
                     irq_level_in = 1'b1;
                  end
               end
            end else begin
               in_frame_in       = 1'b0;
               scanline_count_in = 8'd0;
               irq_pending_in    = 1'b0;
               irq_level_in      = 1'b0;
            end
         end
         default: begin
            rd = 8'd0;
         end
      endcase
   end

   assign result.read_data = rd;
   assign result.irq_out   = irq_level_in;
   assign mem_wr.en        = wr_en & fire;
   assign mem_wr.data      = wr_data;
   assign mem_wr_idx       = item.address[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         exram_mode_ff      <= '0;
         scanline_target_ff <= '0;
         irq_enable_byte_ff <= '0;
         scanline_count_ff  <= '0;
         in_frame_ff        <= 1'b0;
         irq_pending_ff     <= 1'b0;
         irq_level_ff       <= 1'b0;
         mul_a_ff           <= '0;
         mul_b_ff           <= '0;
         product_ff         <= '0;
      end else if (fire) begin
         exram_mode_ff      <= exram_mode_in;
         scanline_target_ff <= scanline_target_in;
         irq_enable_byte_ff <= irq_enable_byte_in;
         scanline_count_ff  <= scanline_count_in;
         in_frame_ff        <= in_frame_in;
         irq_pending_ff     <= irq_pending_in;
         irq_level_ff       <= irq_level_in;
         mul_a_ff           <= mul_a_in;
         mul_b_ff           <= mul_b_in;
         product_ff         <= product_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/scanline_irq_multiplier_exram_unit.sv
// top level: input register, result register and handshake around core and extended ram
// depends on simx_pkg, simx_core, simx_exram
//
//   channel | ports            | direction | payload
//   request | req_valid/stall  | in        | simx_pkg::req_type (kind, address, data, rendering)
//   response| rsp_valid/stall  | out       | simx_pkg::rsp_type (read_data, irq_out)
//
// one item per cycle unless stalled; items pass the input register, then the result register
// the extended ram read is issued at transfer time; the core finishes the item when it advances
// after reset the ram is swept to zero, req_stall high throughout
// a response held by rsp_stall still lets one more request into the input register
`default_nettype none

module scanline_irq_multiplier_exram_unit #(
   parameter int EXRAM_DEPTH = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  simx_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output simx_pkg::rsp_type  rsp_payload
);
   import simx_pkg::*;

   localparam int IDX_W = $clog2(EXRAM_DEPTH);

   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_payload_ff;
   logic         advance;
   logic         accept;
   logic         clearing;
   logic [7:0]   mem_rd_data;
   rsp_type      core_result;
   exram_wr_type mem_wr;
   logic [IDX_W-1:0] mem_wr_idx;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= core_result;
      end
   end

   simx_core #(
      .EXRAM_DEPTH (EXRAM_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (in_item_ff),
      .mem_rd_data (mem_rd_data),
      .result      (core_result),
      .mem_wr      (mem_wr),
      .mem_wr_idx  (mem_wr_idx)
   );

   simx_exram #(
      .EXRAM_DEPTH (EXRAM_DEPTH)
   ) u_exram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (req_payload.address[IDX_W-1:0]),
      .wr       (mem_wr),
      .wr_idx   (mem_wr_idx),
      .rd_data  (mem_rd_data),
      .clearing (clearing)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### tb/sv/tb_scanline_irq_multiplier_exram_unit.sv
// testbench for scanline_irq_multiplier_exram_unit: directed and random frames of bus transfers
// predicts each response in a bus model of its own and checks it; depends on simx_pkg and the rtl
`default_nettype none

module tb_scanline_irq_multiplier_exram_unit;
   import simx_pkg::*;

   localparam int          EXRAM_WORDS = 1024;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int          CYCLE_LIMIT = 300000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   bit      idle_enabled = 1'b1;
   int      error_count = 0;
   int      cycle_count = 0;
   rsp_type awaited_responses[$];

   // bus model state
   logic [1:0]  model_mode;
   logic [7:0]  model_target;
   logic [7:0]  model_irq_enable;
   logic [7:0]  model_line_count;
   logic        model_in_frame;
   logic        model_pending;
   logic        model_irq_line;
   logic [7:0]  model_mul_a;
   logic [7:0]  model_mul_b;
   logic [15:0] model_product;
   logic [7:0]  model_exram [EXRAM_WORDS];

   scanline_irq_multiplier_exram_unit #(
      .EXRAM_DEPTH(EXRAM_WORDS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic rsp_type predict_bus_response(req_type item);
      rsp_type result;
      result = '0;
      case (item.kind)
         KIND_WRITE: begin
            if (item.address >= EXRAM_BASE) begin
               if (model_mode == EXMODE_RW)
                  model_exram[item.address[9:0]] = item.write_data;
               else if (model_mode == EXMODE_NT || model_mode == EXMODE_ATTR)
                  model_exram[item.address[9:0]] = model_in_frame ? item.write_data : 8'h00;
            end else begin
               case (item.address)
                  ADDR_EXMODE: model_mode = item.write_data[1:0];
                  ADDR_TARGET: model_target = item.write_data;
                  ADDR_IRQ:    model_irq_enable = item.write_data;
                  ADDR_MUL_A: begin
                     model_mul_a = item.write_data;
                     model_product = model_mul_a * model_mul_b;
                  end
                  ADDR_MUL_B: begin
                     model_mul_b = item.write_data;
                     model_product = model_mul_a * model_mul_b;
                  end
                  default: ;
               endcase
            end
         end
         KIND_READ: begin
            if (item.address >= EXRAM_BASE) begin
               if (model_mode == EXMODE_RW || model_mode == EXMODE_RO)
                  result.read_data = model_exram[item.address[9:0]];
            end else begin
               case (item.address)
                  ADDR_IRQ: begin
                     result.read_data = {model_pending, model_in_frame, 6'b0};
                     model_pending = 1'b0;
                     model_irq_line = 1'b0;
                  end
                  ADDR_MUL_A: result.read_data = model_product[7:0];
                  ADDR_MUL_B: result.read_data = model_product[15:8];
                  default: ;
               endcase
            end
         end
         KIND_TICK: begin
            if (!item.rendering) begin
               model_in_frame = 1'b0;
               model_line_count = 8'h00;
               model_pending = 1'b0;
               model_irq_line = 1'b0;
            end else begin
               model_in_frame = 1'b1;
               model_line_count = model_line_count + 8'd1;
               if (model_line_count == model_target) begin
                  model_pending = 1'b1;
                  if (model_irq_enable == IRQ_ENABLE_VALUE)
                     model_irq_line = 1'b1;
               end
            end
         end
         default: ;
      endcase
      result.irq_out = model_irq_line;
      return result;
   endfunction

   function automatic req_type bus_item(logic [1:0] kind, logic [15:0] address,
                                        logic [7:0] data, logic rendering);
      req_type item;
      item.kind = kind;
      item.address = address;
      item.write_data = data;
      item.rendering = rendering;
      return item;
   endfunction

   // holds the transfer until taken, then records what it should produce
   task automatic send_bus_item(input req_type item);
      int gap;
      gap = (idle_enabled && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_responses.push_back(predict_bus_response(item));
      @(negedge clock);
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response read_data %h irq_out %b",
                     $time, rsp_payload.read_data, rsp_payload.irq_out);
            error_count++;
         end else begin
            wanted = awaited_responses.pop_front();
            if (rsp_payload.read_data !== wanted.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, wanted.read_data, rsp_payload.read_data);
               error_count++;
            end
            if (rsp_payload.irq_out !== wanted.irq_out) begin
               $display("%0t: irq_out expected %b actual %b",
                        $time, wanted.irq_out, rsp_payload.irq_out);
               error_count++;
            end
         end
      end
   end

   initial begin : rsp_stall_driver
      int span;
      rsp_stall = 1'b0;
      forever begin
         if (idle_enabled && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
         end else begin
            span = $urandom_range(1, 30);
            rsp_stall <= 1'b0;
         end
         repeat (span) @(negedge clock);
      end
   end

   function automatic logic [15:0] random_exram_address();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom_range(EXRAM_BASE, 16'hFFFF));
      return EXRAM_BASE + 16'($urandom_range(0, 7)) + (16'($urandom_range(0, 40)) << 10);
   endfunction

   function automatic req_type random_bus_item();
      req_type item;
      int      pick;
      item = bus_item(2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         item.kind = KIND_WRITE;
         item.address = ADDR_EXMODE;
      end else if (pick < 15) begin
         item.kind = KIND_WRITE;
         item.address = ADDR_TARGET;
      end else if (pick < 21) begin
         item.kind = KIND_WRITE;
         item.address = ADDR_IRQ;
         if ($urandom_range(0, 9) < 7)
            item.write_data = IRQ_ENABLE_VALUE;
      end else if (pick < 31) begin
         item.kind = KIND_WRITE;
         item.address = $urandom_range(0, 1) ? ADDR_MUL_A : ADDR_MUL_B;
      end else if (pick < 44) begin
         item.kind = KIND_READ;
         case ($urandom_range(0, 4))
            0:       item.address = ADDR_EXMODE;
            1:       item.address = ADDR_TARGET;
            2:       item.address = ADDR_MUL_A;
            3:       item.address = ADDR_MUL_B;
            default: item.address = ADDR_IRQ;
         endcase
      end else if (pick < 72) begin
         item.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
         item.address = random_exram_address();
      end else if (pick < 84) begin
         item.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      end else if (pick < 89) begin
         item.kind = KIND_UNUSED;
      end else begin
         item.kind = KIND_TICK;
      end
      return item;
   endfunction

   // a frame: set the target, maybe the enable, a run of rendered lines, then vertical blank
   task automatic run_frames(input int item_budget);
      int sent;
      int lines;
      int extras;
      bit long_frame;
      sent = 0;
      while (sent < item_budget) begin
         long_frame = ($urandom_range(0, 24) == 0);
         send_bus_item(bus_item(KIND_WRITE, ADDR_TARGET,
                                (long_frame || $urandom_range(0, 9) != 0) ?
                                   8'($urandom_range(0, 24)) : 8'($urandom), 1'($urandom)));
         sent++;
         if ($urandom_range(0, 2) == 0) begin
            send_bus_item(bus_item(KIND_WRITE, ADDR_IRQ,
                                   $urandom_range(0, 3) != 0 ? IRQ_ENABLE_VALUE : 8'($urandom),
                                   1'($urandom)));
            sent++;
         end
         lines = long_frame ? $urandom_range(250, 275) : $urandom_range(1, 30);
         repeat (lines) begin
            send_bus_item(bus_item(KIND_TICK, 16'($urandom), 8'($urandom), 1'b1));
            sent++;
            extras = long_frame ? 0 : $urandom_range(0, 3);
            if (long_frame && $urandom_range(0, 7) == 0) begin
               send_bus_item(bus_item(KIND_READ, ADDR_IRQ, 8'($urandom), 1'($urandom)));
               sent++;
            end
            repeat (extras) begin
               send_bus_item(random_bus_item());
               sent++;
            end
         end
         send_bus_item(bus_item(KIND_TICK, 16'($urandom), 8'($urandom), 1'b0));
         sent++;
      end
   endtask

   task automatic test_multiplier();
      send_bus_item(bus_item(KIND_WRITE, ADDR_MUL_A, 8'hFF, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, ADDR_MUL_B, 8'hFF, 1'b0));
      send_bus_item(bus_item(KIND_READ, ADDR_MUL_A, 8'h00, 1'b0));
      send_bus_item(bus_item(KIND_READ, ADDR_MUL_B, 8'h00, 1'b0));
   endtask

   task automatic test_scanline_irq();
      send_bus_item(bus_item(KIND_WRITE, ADDR_TARGET, 8'h02, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, ADDR_IRQ, IRQ_ENABLE_VALUE, 1'b0));
      send_bus_item(bus_item(KIND_TICK, 16'h0000, 8'h00, 1'b1));
      send_bus_item(bus_item(KIND_TICK, 16'h0000, 8'h00, 1'b1));
      send_bus_item(bus_item(KIND_READ, ADDR_IRQ, 8'h00, 1'b0));
      // any enable value other than the exact one leaves the line low
      send_bus_item(bus_item(KIND_WRITE, ADDR_IRQ, 8'h81, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, ADDR_TARGET, 8'h03, 1'b0));
      send_bus_item(bus_item(KIND_TICK, 16'h0000, 8'h00, 1'b1));
      send_bus_item(bus_item(KIND_TICK, 16'h0000, 8'h00, 1'b0));
   endtask

   task automatic test_exram_access();
      send_bus_item(bus_item(KIND_WRITE, ADDR_EXMODE, 8'hFE, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, 16'hFFFF, 8'hA5, 1'b0));
      send_bus_item(bus_item(KIND_READ, 16'h5FFF, 8'h00, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, ADDR_EXMODE, 8'h03, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, 16'h5FFF, 8'h00, 1'b0));
      send_bus_item(bus_item(KIND_READ, 16'hFFFF, 8'h00, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, ADDR_EXMODE, 8'h00, 1'b0));
      send_bus_item(bus_item(KIND_WRITE, 16'h5C01, 8'h5A, 1'b0));
      send_bus_item(bus_item(KIND_READ, 16'h5C01, 8'h00, 1'b0));
   endtask

   task automatic test_unmapped_and_unused();
      send_bus_item(bus_item(KIND_WRITE, 16'h0000, 8'hFF, 1'b1));
      send_bus_item(bus_item(KIND_READ, 16'h5BFF, 8'hFF, 1'b1));
      send_bus_item(bus_item(KIND_UNUSED, ADDR_IRQ, 8'hFF, 1'b1));
   endtask

   task automatic test_random_frames();
      run_frames(1550);
   endtask

   task automatic test_back_to_back();
      idle_enabled = 1'b0;
      run_frames(200);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      model_mode = 2'd0;
      model_target = 8'h00;
      model_irq_enable = 8'h00;
      model_line_count = 8'h00;
      model_in_frame = 1'b0;
      model_pending = 1'b0;
      model_irq_line = 1'b0;
      model_mul_a = 8'h00;
      model_mul_b = 8'h00;
      model_product = 16'h0000;
      foreach (model_exram[i]) model_exram[i] = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_multiplier();
      test_scanline_irq();
      test_exram_access();
      test_unmapped_and_unused();
      test_random_frames();
      test_back_to_back();

      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
